// ----- rtl/remap_pixel_interpolator_assert.svh -----
// Assertion macros shared by the remap pixel interpolator RTL.
`ifndef REMAP_PIXEL_INTERPOLATOR_ASSERT_SVH
`define REMAP_PIXEL_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RPI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RPI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/rpi_pkg.sv -----
// Package with shared types, codes and the cubic weight table.
`timescale 1ns / 1ps
`default_nettype none
package rpi_pkg;

	localparam int COL_W = 10;
	localparam int ROW_W = 10;
	localparam int PIX_W = 8;
	localparam int FRAC_W = 8;
	localparam int CFG_W = 11;
	localparam int CFG_IDX_W = 2;
	localparam int WGT_W = 10;

	localparam int RST_IMAGE_WIDTH = 1024;
	localparam int RST_IMAGE_HEIGHT = 1024;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	localparam logic MODE_BILINEAR = 1'b0;
	localparam logic MODE_BICUBIC = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTERP_MODE = 2'd2;

	typedef logic signed [WGT_W-1:0] wgt_t;
	typedef wgt_t [3:0] wset_t;
	typedef wset_t [255:0] wtab_t;

	// Scale down by 2**18, truncating toward zero for negative values too.
	function automatic int div_q18(input longint n);
		longint q;
		if (n < 0) q = -((-n) >>> 18);
		else q = n >>> 18;
		return int'(q);
	endfunction

	// Keys kernel (a = -0.75) sampled at four taps, scaled by 256 and rounded.
	function automatic wset_t cubic_set(input int f);
		longint t;
		longint x;
		longint u;
		longint n0;
		longint n1;
		longint n2;
		int w0;
		int w1;
		int w2;
		int w3;
		wset_t s;
		t = longint'(f);
		x = 256 + t;
		u = 256 - t;
		n0 = -3 * x * x * x + 15 * 256 * x * x - 24 * 65536 * x
			+ 12 * (longint'(1) << 24) + (longint'(1) << 17);
		n1 = 5 * t * t * t - 9 * 256 * t * t
			+ 256 * (longint'(1) << 18) + (longint'(1) << 17);
		n2 = 5 * u * u * u - 9 * 256 * u * u
			+ 256 * (longint'(1) << 18) + (longint'(1) << 17);
		w0 = div_q18(n0);
		w1 = div_q18(n1);
		w2 = div_q18(n2);
		w3 = 256 - w0 - w1 - w2;
		s[0] = WGT_W'(w0);
		s[1] = WGT_W'(w1);
		s[2] = WGT_W'(w2);
		s[3] = WGT_W'(w3);
		return s;
	endfunction

	function automatic wtab_t build_wtab();
		wtab_t tab;
		for (int f = 0; f < 256; f++) begin
			tab[f] = cubic_set(f);
		end
		return tab;
	endfunction

	localparam wtab_t CUBIC_TAB = build_wtab();

endpackage
`default_nettype wire

// ----- rtl/rpi_if.sv -----
// Request and result channel interfaces of the remap pixel interpolator.
`timescale 1ns / 1ps
`default_nettype none
interface rpi_req_if import rpi_pkg::*; ();
	logic valid;
	logic ready;
	logic req_type;
	logic [COL_W-1:0] col;
	logic [ROW_W-1:0] row;
	logic [PIX_W-1:0] pixel_in;
	logic [FRAC_W-1:0] frac_x;
	logic [FRAC_W-1:0] frac_y;

	modport source(output valid, req_type, col, row, pixel_in, frac_x, frac_y, input ready);
	modport sink(input valid, req_type, col, row, pixel_in, frac_x, frac_y, output ready);
endinterface

interface rpi_res_if import rpi_pkg::*; ();
	logic valid;
	logic ready;
	logic [PIX_W-1:0] sample_value;

	modport source(output valid, sample_value, input ready);
	modport sink(input valid, sample_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/remap_pixel_interpolator.sv -----
// Remap pixel interpolator: frame store plus microcoded bilinear/bicubic sampler.
`timescale 1ns / 1ps
`default_nettype none
`include "remap_pixel_interpolator_assert.svh"

// The block keeps one 8-bit image plane in a single-port frame memory of
// MAX_WIDTH*MAX_HEIGHT bytes, addressed row*width+col; its contents are
// undefined until written and there is no clearing pass after reset. A write
// request stores one pixel and returns nothing; a sample request returns one
// interpolated pixel. Each request runs a short micro-program that reads the
// frame memory one pixel per cycle, 4 pixels for a bilinear sample and 16
// for a bicubic one; the request port is busy until the program's last step
// and accepts the next request in the cycle after that. A finished sample
// waits in an output register, so a new request may be taken while it is
// still pending; only a second result stalls the program at its last step.
// Width, height and mode are written through the configuration port while
// the block is idle; width and height are clamped to 4..MAX_WIDTH/MAX_HEIGHT.
module remap_pixel_interpolator import rpi_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	rpi_req_if.sink req,
	rpi_res_if.source res,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_W-1:0] cfg_data
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = $clog2(DEPTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int WHW = (WW > HW) ? WW : HW;
	localparam int CW = (WHW > COL_W) ? WHW : COL_W;
	localparam int ZWW = (WW > CFG_W) ? WW : CFG_W;
	localparam int ZHW = (HW > CFG_W) ? HW : CFG_W;
	localparam int RST_W = (RST_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_IMAGE_WIDTH;
	localparam int RST_H = (RST_IMAGE_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_IMAGE_HEIGHT;
	localparam int XAW = 20;
	localparam int YAW = 32;
	localparam int XPW = WGT_W + PIX_W + 1;
	localparam int YPW = WGT_W + XAW;
	localparam int UPW = 5;

	// Sequencer codes.
	localparam logic [1:0] SQ_NEXT = 2'd0;
	localparam logic [1:0] SQ_BR_WRITE = 2'd1;
	localparam logic [1:0] SQ_BR_BILIN = 2'd2;
	localparam logic [1:0] SQ_END = 2'd3;

	localparam logic [UPW-1:0] UA_SETUP = 5'd0;
	localparam logic [UPW-1:0] UA_MUL = 5'd1;
	localparam logic [UPW-1:0] UA_MODE = 5'd2;
	localparam logic [UPW-1:0] UA_BILIN = 5'd22;
	localparam logic [UPW-1:0] UA_WRITE = 5'd29;

	typedef struct packed {
		logic setup;
		logic mul;
		logic rd;
		logic wr;
		logic nl;
		logic mx;
		logic mx_clr;
		logic [1:0] mx_sel;
		logic my;
		logic my_clr;
		logic [1:0] my_sel;
		logic outp;
		logic [1:0] seq;
		logic [UPW-1:0] target;
	} uword_t;

	// Micro-program: a pixel read in one step is weighted in the next, a line
	// sum is folded into the vertical sum in the step after its last tap.
	function automatic uword_t ucode(input logic [UPW-1:0] a);
		uword_t u;
		u = '0;
		u.seq = SQ_NEXT;
		unique case (a)
			UA_SETUP: u.setup = 1'b1;
			UA_MUL: begin
				u.mul = 1'b1;
				u.seq = SQ_BR_WRITE;
				u.target = UA_WRITE;
			end
			UA_MODE: begin
				u.seq = SQ_BR_BILIN;
				u.target = UA_BILIN;
			end
			5'd3: u.rd = 1'b1;
			5'd4, 5'd8, 5'd12, 5'd16: begin
				u.rd = 1'b1;
				u.mx = 1'b1;
				u.mx_clr = 1'b1;
				u.mx_sel = 2'd0;
				u.my = (a != 5'd4);
				u.my_clr = (a == 5'd8);
				u.my_sel = (a == 5'd12) ? 2'd1 : ((a == 5'd16) ? 2'd2 : 2'd0);
			end
			5'd5, 5'd9, 5'd13, 5'd17: begin
				u.rd = 1'b1;
				u.mx = 1'b1;
				u.mx_sel = 2'd1;
			end
			5'd6, 5'd10, 5'd14, 5'd18: begin
				u.rd = 1'b1;
				u.nl = (a != 5'd18);
				u.mx = 1'b1;
				u.mx_sel = 2'd2;
			end
			5'd7, 5'd11, 5'd15: begin
				u.rd = 1'b1;
				u.mx = 1'b1;
				u.mx_sel = 2'd3;
			end
			5'd19: begin
				u.mx = 1'b1;
				u.mx_sel = 2'd3;
			end
			5'd20: begin
				u.my = 1'b1;
				u.my_sel = 2'd3;
			end
			5'd21, 5'd28: begin
				u.outp = 1'b1;
				u.seq = SQ_END;
			end
			UA_BILIN: u.rd = 1'b1;
			5'd23: begin
				u.rd = 1'b1;
				u.nl = 1'b1;
				u.mx = 1'b1;
				u.mx_clr = 1'b1;
				u.mx_sel = 2'd0;
			end
			5'd24: begin
				u.rd = 1'b1;
				u.mx = 1'b1;
				u.mx_sel = 2'd1;
			end
			5'd25: begin
				u.rd = 1'b1;
				u.mx = 1'b1;
				u.mx_clr = 1'b1;
				u.mx_sel = 2'd0;
				u.my = 1'b1;
				u.my_clr = 1'b1;
				u.my_sel = 2'd0;
			end
			5'd26: begin
				u.mx = 1'b1;
				u.mx_sel = 2'd1;
			end
			5'd27: begin
				u.my = 1'b1;
				u.my_sel = 2'd1;
			end
			UA_WRITE: begin
				u.wr = 1'b1;
				u.seq = SQ_END;
			end
			default: u.seq = SQ_END;
		endcase
		return u;
	endfunction

	// Configuration, stored already clamped to the supported plane size.
	logic [WW-1:0] ew_q;
	logic [HW-1:0] eh_q;
	logic mode_q;

	// Request capture.
	logic req_type_q;
	logic [COL_W-1:0] col_raw_q;
	logic [ROW_W-1:0] row_raw_q;
	logic [PIX_W-1:0] wdata_q;
	wset_t wx_q;
	wset_t wy_q;

	// Sequencer and datapath.
	logic busy_q;
	logic [UPW-1:0] upc_q;
	logic [CW-1:0] m_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] col_q;
	logic wr_ok_q;
	logic [AW-1:0] lbase_q;
	logic [PIX_W-1:0] pix_q;
	logic signed [XAW-1:0] xacc_q;
	logic signed [YAW-1:0] yacc_q;
	logic res_vld_q;
	logic [PIX_W-1:0] res_val_q;

	logic [PIX_W-1:0] mem [DEPTH];

	uword_t cw;
	logic adv;
	logic act;
	logic req_acc;
	logic [AW-1:0] addr;
	logic [CW-1:0] wc;
	logic [CW-1:0] hc;
	logic [CW-1:0] colc;
	logic [CW-1:0] rowc;
	logic [CW-1:0] colsat;
	logic [CW-1:0] rowsat;
	logic [CW-1:0] mdec;
	logic [CW-1:0] ndec;
	logic [CW-1:0] mbic;
	logic [CW-1:0] nbic;
	logic [2*CW-1:0] mul_p;
	wgt_t wxs;
	wgt_t wys;
	logic signed [XPW-1:0] xprod;
	logic signed [YPW-1:0] yprod;
	logic signed [YAW-1:0] ybias;
	logic signed [YAW-17:0] yq;
	logic [PIX_W-1:0] yclamp;
	wset_t wx_new;
	wset_t wy_new;
	logic [ZWW-1:0] cfg_zw;
	logic [ZHW-1:0] cfg_zh;

	assign cw = ucode(upc_q);
	assign req_acc = req.valid && req.ready;
	assign req.ready = !busy_q;
	assign adv = !(cw.outp && res_vld_q && !res.ready);
	assign act = busy_q && adv;
	assign res.valid = res_vld_q;
	assign res.sample_value = res_val_q;

	// Weight sets chosen at acceptance; bilinear uses the first two taps only.
	always_comb begin
		wx_new = CUBIC_TAB[req.frac_x];
		wy_new = CUBIC_TAB[req.frac_y];
		if (mode_q == MODE_BILINEAR) begin
			wx_new = '0;
			wy_new = '0;
			wx_new[0] = wgt_t'(10'sd256 - $signed({2'b00, req.frac_x}));
			wx_new[1] = $signed({2'b00, req.frac_x});
			wy_new[0] = wgt_t'(10'sd256 - $signed({2'b00, req.frac_y}));
			wy_new[1] = $signed({2'b00, req.frac_y});
		end
	end

	// Window origin: saturate to size-2, then for bicubic back off by one
	// and keep the 4x4 window inside the plane.
	assign wc = CW'(ew_q);
	assign hc = CW'(eh_q);
	assign colc = CW'(col_raw_q);
	assign rowc = CW'(row_raw_q);
	assign colsat = (colc > wc - CW'(2)) ? wc - CW'(2) : colc;
	assign rowsat = (rowc > hc - CW'(2)) ? hc - CW'(2) : rowc;
	assign mdec = (colsat == '0) ? '0 : colsat - CW'(1);
	assign ndec = (rowsat == '0) ? '0 : rowsat - CW'(1);
	assign mbic = (mdec > wc - CW'(4)) ? wc - CW'(4) : mdec;
	assign nbic = (ndec > hc - CW'(4)) ? hc - CW'(4) : ndec;

	assign mul_p = (2 * CW)'(n_q) * (2 * CW)'(wc);
	assign addr = lbase_q + AW'(col_q);

	assign wxs = wx_q[cw.mx_sel];
	assign wys = wy_q[cw.my_sel];
	assign xprod = wxs * $signed({1'b0, pix_q});
	assign yprod = wys * xacc_q;

	// Divide by 65536 toward zero, then clamp to the pixel range.
	assign ybias = (yacc_q < 0) ? yacc_q + YAW'(65535) : yacc_q;
	assign yq = ybias[YAW-1:16];
	assign yclamp = (yq < 0) ? '0 : ((yq > 255) ? 8'd255 : yq[PIX_W-1:0]);

	assign cfg_zw = ZWW'(cfg_data);
	assign cfg_zh = ZHW'(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ew_q <= WW'(RST_W);
			eh_q <= HW'(RST_H);
			mode_q <= MODE_BILINEAR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH: begin
					if (cfg_zw < ZWW'(4)) ew_q <= WW'(4);
					else if (cfg_zw > ZWW'(MAX_WIDTH)) ew_q <= WW'(MAX_WIDTH);
					else ew_q <= WW'(cfg_zw);
				end
				REG_IMAGE_HEIGHT: begin
					if (cfg_zh < ZHW'(4)) eh_q <= HW'(4);
					else if (cfg_zh > ZHW'(MAX_HEIGHT)) eh_q <= HW'(MAX_HEIGHT);
					else eh_q <= HW'(cfg_zh);
				end
				REG_INTERP_MODE: mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			upc_q <= UA_SETUP;
			res_vld_q <= 1'b0;
		end else begin
			if (req_acc) begin
				busy_q <= 1'b1;
				upc_q <= UA_SETUP;
			end else if (act) begin
				unique case (cw.seq)
					SQ_NEXT: upc_q <= upc_q + UPW'(1);
					SQ_BR_WRITE: upc_q <= (req_type_q == REQ_WRITE) ? cw.target
						: upc_q + UPW'(1);
					SQ_BR_BILIN: upc_q <= (mode_q == MODE_BILINEAR) ? cw.target
						: upc_q + UPW'(1);
					SQ_END: busy_q <= 1'b0;
					default: busy_q <= 1'b0;
				endcase
			end
			if (act && cw.outp) begin
				res_vld_q <= 1'b1;
			end else if (res.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_type_q <= req.req_type;
			col_raw_q <= req.col;
			row_raw_q <= req.row;
			wdata_q <= req.pixel_in;
			wx_q <= wx_new;
			wy_q <= wy_new;
		end
		if (act && cw.setup) begin
			if (req_type_q == REQ_WRITE) begin
				m_q <= colc;
				n_q <= rowc;
			end else if (mode_q == MODE_BILINEAR) begin
				m_q <= colsat;
				n_q <= rowsat;
			end else begin
				m_q <= mbic;
				n_q <= nbic;
			end
			wr_ok_q <= (colc < wc) && (rowc < hc);
		end
		if (act && cw.mul) begin
			lbase_q <= mul_p[AW-1:0];
			col_q <= m_q;
		end
		if (act && cw.nl) begin
			lbase_q <= lbase_q + AW'(ew_q);
			col_q <= m_q;
		end else if (act && cw.rd) begin
			col_q <= col_q + CW'(1);
		end
		if (act && cw.mx) begin
			xacc_q <= (cw.mx_clr ? XAW'(0) : xacc_q) + XAW'(xprod);
		end
		if (act && cw.my) begin
			yacc_q <= (cw.my_clr ? YAW'(0) : yacc_q) + YAW'(yprod);
		end
		if (act && cw.outp) begin
			res_val_q <= yclamp;
		end
	end

	// Single-port frame memory with registered read data.
	always_ff @(posedge clk) begin
		if (act && cw.wr && wr_ok_q) begin
			mem[addr] <= wdata_q;
		end
		if (act && cw.rd) begin
			pix_q <= mem[addr];
		end
	end

	`RPI_ASSERT_NEXT(a_accept_starts_program, req_acc, busy_q && upc_q == UA_SETUP,
		"accepted request did not start the micro-program")
	`RPI_ASSERT_NOW(a_no_rd_wr_same_step, busy_q, !(cw.rd && cw.wr),
		"frame memory read and write in the same step")
	`RPI_ASSERT_NOW(a_write_gives_no_result, busy_q && req_type_q == REQ_WRITE, !cw.outp,
		"write request reached a result step")
	`RPI_ASSERT_NEXT(a_pending_result_held, res_vld_q && !res.ready,
		res_vld_q && $stable(res_val_q), "pending result was lost or overwritten")

endmodule
`default_nettype wire
